// ----- rtl/dipcl_pkg.sv -----
package dipcl_pkg;

    localparam int RAM_BYTES    = 65536;
    localparam int SECTOR_BYTES = 256;

    // Highest address the loader may not write to, and the last byte of a sector.
    localparam logic [15:0] TOP_ADDR  = 16'(RAM_BYTES - 1);
    localparam logic [7:0]  LAST_BYTE = 8'(SECTOR_BYTES - 1);

    localparam logic [5:0] TRACKS_MAX        = 6'd42;
    localparam logic [5:0] TRACK_COUNT_RESET = 6'd35;

    // Byte positions within a sector.
    localparam logic [7:0] IDX_LINK_TRACK  = 8'd0;
    localparam logic [7:0] IDX_LINK_SECTOR = 8'd1;
    localparam logic [7:0] IDX_LOAD_LO     = 8'd2;
    localparam logic [7:0] IDX_LOAD_HI     = 8'd3;
    localparam logic [7:0] FULL_USED       = 8'd254;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_REQ   = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_FAIL  = 2'd3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic       cmd;
        logic [7:0] start_track;
        logic [7:0] start_sector;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ram_address;
        logic [7:0]  ram_data;
        logic [17:0] image_offset;
        logic [5:0]  req_track;
        logic [4:0]  req_sector;
        logic [15:0] end_address;
        logic        last;
    } t_result;

    // Up to two results from one item, in delivery order.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_res_pair;

    // Sectors per track in each speed zone; zero for a track that does not exist.
    function automatic logic [4:0] zone_count(logic [7:0] t);
        logic [4:0] z;
        if (t == 8'd0 || t > {2'b00, TRACKS_MAX}) z = 5'd0;
        else if (t <= 8'd17) z = 5'd21;
        else if (t <= 8'd24) z = 5'd19;
        else if (t <= 8'd30) z = 5'd18;
        else z = 5'd17;
        return z;
    endfunction

    // Number of sectors on all tracks below track t (t from 1 to 43).
    function automatic logic [9:0] sectors_before(logic [5:0] t);
        logic [9:0] tw;
        logic [9:0] s;
        tw = {4'd0, t};
        if (t <= 6'd1) s = 10'd0;
        else if (t <= 6'd18) s = 10'((tw - 10'd1) * 10'd21);
        else if (t <= 6'd25) s = 10'(10'd357 + (tw - 10'd18) * 10'd19);
        else if (t <= 6'd31) s = 10'(10'd490 + (tw - 10'd25) * 10'd18);
        else s = 10'(10'd598 + (tw - 10'd31) * 10'd17);
        return s;
    endfunction

    function automatic logic sector_ok(logic [7:0] t, logic [7:0] s, logic [5:0] tc);
        logic [4:0] z;
        z = zone_count(t);
        return (z != 5'd0) && (t <= {2'b00, tc}) && (s < {3'b000, z});
    endfunction

    function automatic logic [17:0] sector_offset(logic [7:0] t, logic [7:0] s);
        logic [9:0] n;
        n = 10'(sectors_before(t[5:0]) + {2'b00, s});
        return {n, 8'h00};
    endfunction

    function automatic logic [9:0] disk_total(logic [5:0] tc);
        logic [5:0] n;
        n = (tc > TRACKS_MAX) ? TRACKS_MAX : tc;
        return sectors_before(6'(n + 6'd1));
    endfunction

    function automatic t_result mk_write(logic [15:0] addr, logic [7:0] data);
        t_result r;
        r = '0;
        r.kind = KIND_WRITE;
        r.ram_address = addr;
        r.ram_data = data;
        return r;
    endfunction

    function automatic t_result mk_req(logic [7:0] t, logic [7:0] s);
        t_result r;
        r = '0;
        r.kind = KIND_REQ;
        r.image_offset = sector_offset(t, s);
        r.req_track = t[5:0];
        r.req_sector = s[4:0];
        return r;
    endfunction

    // End of a load: failure when nothing was written, otherwise the end address.
    function automatic t_result mk_finish(logic [15:0] wp, logic [15:0] la);
        t_result r;
        r = '0;
        if (wp == la) begin
            r.kind = KIND_FAIL;
        end else begin
            r.kind = KIND_DONE;
            r.end_address = wp;
        end
        return r;
    endfunction

    function automatic t_result mk_fail();
        t_result r;
        r = '0;
        r.kind = KIND_FAIL;
        return r;
    endfunction

endpackage

// ----- rtl/disk_image_prg_chain_loader_top.sv -----
// An accepted item is registered, then turned into results held in the result queue.
// Throughput: one item per cycle while the result queue has room; the last byte of a
// sector may cause two results, which a four-entry result queue absorbs; results leave
// at up to one per cycle.
// Reset: synchronous, active low; clears the load state and sets track_count to 35.
module disk_image_prg_chain_loader_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dipcl_pkg::t_item   i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dipcl_pkg::t_result o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [5:0]         i_cfg_data
);

    // The core holds the input register, the chain-following state and the track
    // count register; each item it takes is turned into its results combinationally
    // and handed to the result queue in delivery order.
    dipcl_pkg::t_res_pair push;
    logic                 can_push;

    // The track count register is always free to be written.
    assign o_cfg_ready = 1'b1;

    dipcl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_can_push  (can_push),
        .o_push      (push)
    );

    // The result queue parts the two sides, so a stalled output does not hold up
    // new items until the queue can no longer take a full burst.
    dipcl_resq u_resq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_can_push  (can_push),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/dipcl_core.sv -----
module dipcl_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dipcl_pkg::t_item    i_in,
    input  logic                i_cfg_valid,
    input  logic [5:0]          i_cfg_data,
    input  logic                i_can_push,
    output dipcl_pkg::t_res_pair o_push
);

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_LOAD = 1'b1;

    dipcl_pkg::t_item r_item;
    logic             r_item_valid;
    logic             fire;

    logic        r_phase,           n_phase;
    logic [7:0]  r_byte_index,      n_byte_index;
    logic [7:0]  r_link_track,      n_link_track;
    logic [7:0]  r_link_sector,     n_link_sector;
    logic [7:0]  r_bytes_used,      n_bytes_used;
    logic [15:0] r_write_pos,       n_write_pos;
    logic [15:0] r_load_address,    n_load_address;
    logic [9:0]  r_sectors_read,    n_sectors_read;
    logic        r_on_first,        n_on_first;
    logic [5:0]  r_track_count;
    logic [9:0]  r_disk_total;

    dipcl_pkg::t_result res;
    logic [1:0]  cnt;
    logic        stop;
    logic [7:0]  b;
    logic [7:0]  used;
    logic [7:0]  p;
    logic [7:0]  skip;
    logic [15:0] wp;
    logic [9:0]  sr;

    assign fire       = r_item_valid && i_can_push;
    assign o_in_ready = !r_item_valid || i_can_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_item_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count <= dipcl_pkg::TRACK_COUNT_RESET;
            r_disk_total  <= dipcl_pkg::disk_total(dipcl_pkg::TRACK_COUNT_RESET);
        end else if (i_cfg_valid) begin
            r_track_count <= i_cfg_data;
            r_disk_total  <= dipcl_pkg::disk_total(i_cfg_data);
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_byte_index   = r_byte_index;
        n_link_track   = r_link_track;
        n_link_sector  = r_link_sector;
        n_bytes_used   = r_bytes_used;
        n_write_pos    = r_write_pos;
        n_load_address = r_load_address;
        n_sectors_read = r_sectors_read;
        n_on_first     = r_on_first;
        o_push         = '0;
        res            = '0;
        cnt            = 2'd0;
        stop           = 1'b0;
        b              = r_item.data_byte;
        used           = 8'd0;
        p              = 8'(r_byte_index - 8'd2);
        skip           = r_on_first ? 8'd2 : 8'd0;
        wp             = r_write_pos;
        sr             = 10'(r_sectors_read + 10'd1);

        if (fire) begin
            if (r_item.cmd == dipcl_pkg::CMD_START) begin
                n_link_track   = 8'd0;
                n_link_sector  = 8'd0;
                n_bytes_used   = 8'd0;
                n_write_pos    = 16'd0;
                n_load_address = 16'd0;
                n_sectors_read = 10'd0;
                n_on_first     = 1'b1;
                n_byte_index   = 8'd0;
                if (dipcl_pkg::sector_ok(r_item.start_track, r_item.start_sector,
                                         r_track_count)) begin
                    n_phase = PH_LOAD;
                    o_push.first = dipcl_pkg::mk_req(r_item.start_track,
                                                     r_item.start_sector);
                end else begin
                    n_phase = PH_IDLE;
                    o_push.first = dipcl_pkg::mk_fail();
                end
                cnt = 2'd1;
            end else if (r_phase == PH_LOAD) begin
                if (r_byte_index == dipcl_pkg::IDX_LINK_TRACK) begin
                    n_link_track = b;
                end else if (r_byte_index == dipcl_pkg::IDX_LINK_SECTOR) begin
                    n_link_sector = b;
                    if (r_link_track != 8'd0) used = dipcl_pkg::FULL_USED;
                    else if (b >= 8'd2) used = 8'(b - 8'd1);
                    else used = 8'd0;
                    n_bytes_used = used;
                    // A first sector too short to hold a load address fails at once.
                    if (r_on_first && used < 8'd2) begin
                        n_phase = PH_IDLE;
                        o_push.first = dipcl_pkg::mk_fail();
                        cnt = 2'd1;
                        stop = 1'b1;
                    end
                end else if (r_on_first && r_byte_index <= dipcl_pkg::IDX_LOAD_HI) begin
                    if (r_byte_index == dipcl_pkg::IDX_LOAD_LO) begin
                        n_load_address = {8'h00, b};
                    end else begin
                        n_load_address = {b, r_load_address[7:0]};
                        n_write_pos    = {b, r_load_address[7:0]};
                    end
                end else if (p >= skip && p < r_bytes_used) begin
                    if (r_write_pos >= dipcl_pkg::TOP_ADDR) begin
                        // Pointer already at the top when a sector's payload opens.
                        if (p == skip) begin
                            n_phase = PH_IDLE;
                            o_push.first = dipcl_pkg::mk_finish(r_write_pos,
                                                                r_load_address);
                            cnt = 2'd1;
                            stop = 1'b1;
                        end
                    end else begin
                        o_push.first = dipcl_pkg::mk_write(r_write_pos, b);
                        cnt = 2'd1;
                        wp = 16'(r_write_pos + 16'd1);
                        n_write_pos = wp;
                    end
                end

                if (!stop) begin
                    if (r_byte_index == dipcl_pkg::LAST_BYTE) begin
                        n_sectors_read = sr;
                        if (r_link_track == 8'd0 || sr >= r_disk_total
                            || !dipcl_pkg::sector_ok(r_link_track, r_link_sector,
                                                     r_track_count)) begin
                            n_phase = PH_IDLE;
                            res = dipcl_pkg::mk_finish(wp, r_load_address);
                        end else begin
                            n_on_first = 1'b0;
                            n_byte_index = 8'd0;
                            res = dipcl_pkg::mk_req(r_link_track, r_link_sector);
                        end
                        if (cnt == 2'd0) o_push.first = res;
                        else o_push.second = res;
                        cnt = 2'(cnt + 2'd1);
                    end else begin
                        n_byte_index = 8'(r_byte_index + 8'd1);
                    end
                end
            end
        end

        if (cnt == 2'd1) o_push.first.last = 1'b1;
        if (cnt == 2'd2) o_push.second.last = 1'b1;
        o_push.cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_byte_index   <= 8'd0;
            r_link_track   <= 8'd0;
            r_link_sector  <= 8'd0;
            r_bytes_used   <= 8'd0;
            r_write_pos    <= 16'd0;
            r_load_address <= 16'd0;
            r_sectors_read <= 10'd0;
            r_on_first     <= 1'b1;
        end else begin
            r_phase        <= n_phase;
            r_byte_index   <= n_byte_index;
            r_link_track   <= n_link_track;
            r_link_sector  <= n_link_sector;
            r_bytes_used   <= n_bytes_used;
            r_write_pos    <= n_write_pos;
            r_load_address <= n_load_address;
            r_sectors_read <= n_sectors_read;
            r_on_first     <= n_on_first;
        end
    end

    // Two results from one item only come from the last byte of a sector.
    a_two_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |-> (r_byte_index == dipcl_pkg::LAST_BYTE))
        else $error("two results away from the end of a sector");

    // Nothing is produced while the result queue lacks room.
    a_no_push_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_can_push |-> (o_push.cnt == 2'd0))
        else $error("results produced while the queue is full");

    // A load only becomes active through a start item.
    a_load_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE && fire && r_item.cmd == dipcl_pkg::CMD_BYTE)
        |=> (r_phase == PH_IDLE))
        else $error("byte item started a load");

endmodule

// ----- rtl/dipcl_resq.sv -----
module dipcl_resq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dipcl_pkg::t_res_pair i_push,
    output logic                 o_can_push,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dipcl_pkg::t_result   o_out
);

    dipcl_pkg::t_result r_mem [dipcl_pkg::Q_DEPTH];
    logic [dipcl_pkg::Q_AW-1:0] r_wr;
    logic [dipcl_pkg::Q_AW-1:0] r_rd;
    logic [dipcl_pkg::Q_AW:0]   r_count;
    logic [dipcl_pkg::Q_AW-1:0] wr_next;
    logic                       pop;

    assign wr_next     = dipcl_pkg::Q_AW'(r_wr + 1'b1);
    assign o_out_valid = (r_count != '0);
    assign o_out       = r_mem[r_rd];
    assign pop         = o_out_valid && i_out_ready;
    // Room for the largest burst one item can cause.
    assign o_can_push  = (r_count <= (dipcl_pkg::Q_AW+1)'(dipcl_pkg::Q_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= dipcl_pkg::Q_AW'(r_wr + i_push.cnt);
            r_rd    <= dipcl_pkg::Q_AW'(r_rd + pop);
            r_count <= (dipcl_pkg::Q_AW+1)'(r_count + i_push.cnt - pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (dipcl_pkg::Q_AW+1)'(dipcl_pkg::Q_DEPTH))
        else $error("result queue overflow");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.cnt == 2'd0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("result queue count lost track of a pop");

endmodule

// ----- dv/disk_image_prg_chain_loader_top_tb.sv -----
`timescale 1ns / 1ps

module disk_image_prg_chain_loader_top_tb;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 16;
    localparam int CHAIN_BYTES   = 24;
    localparam int ROOM_BYTES    = 8;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    dipcl_pkg::t_item     i_in        = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [5:0]           i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    dipcl_pkg::t_result   o_out;
    logic                 o_cfg_ready;

    disk_image_prg_chain_loader_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Loader state as the block should hold it, updated as each item is accepted.
    logic [5:0]  tracks_cfg = dipcl_pkg::TRACK_COUNT_RESET;
    logic        ld_active  = 1'b0;
    logic [7:0]  ld_idx     = '0;
    logic [7:0]  nx_trk     = '0;
    logic [7:0]  nx_sec     = '0;
    logic [7:0]  used_len   = '0;
    logic [15:0] wr_ptr     = '0;
    logic [15:0] load_base  = '0;
    logic [9:0]  secs_done  = '0;
    logic        first_sec  = 1'b1;

    // Results still owed by the block, oldest first.
    dipcl_pkg::t_result pending_results[$];
    dipcl_pkg::t_result oldest;

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_req  = 1'b0;

    int fail_count  = 0;
    int sent_items  = 0;
    int cycle_count = 0;
    int n_writes    = 0;
    int n_reqs      = 0;
    int n_done      = 0;
    int n_failed    = 0;
    int mid_tracks  = 0;

    // Sectors per track in each speed zone; zero for a track the format lacks.
    function automatic int zone_sectors(int t);
        if (t < 1 || t > dipcl_pkg::TRACKS_MAX) return 0;
        if (t <= 17) return 21;
        if (t <= 24) return 19;
        if (t <= 30) return 18;
        return 17;
    endfunction

    function automatic bit link_ok(logic [7:0] t, logic [7:0] s);
        int z;
        z = zone_sectors(t);
        return z != 0 && t <= tracks_cfg && s < z;
    endfunction

    function automatic logic [17:0] image_pos(logic [7:0] t, logic [7:0] s);
        int acc;
        int k;
        acc = 0;
        for (k = 1; k < t && k <= dipcl_pkg::TRACKS_MAX; k++) begin
            acc += zone_sectors(k) * dipcl_pkg::SECTOR_BYTES;
        end
        return 18'(acc + s * dipcl_pkg::SECTOR_BYTES);
    endfunction

    function automatic int disk_sectors();
        int acc;
        int k;
        acc = 0;
        for (k = 1; k <= tracks_cfg && k <= dipcl_pkg::TRACKS_MAX; k++) acc += zone_sectors(k);
        return acc;
    endfunction

    function automatic dipcl_pkg::t_result blank_result(logic [1:0] k);
        dipcl_pkg::t_result r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic dipcl_pkg::t_result read_request(logic [7:0] t, logic [7:0] s);
        dipcl_pkg::t_result r;
        r = blank_result(dipcl_pkg::KIND_REQ);
        r.image_offset = image_pos(t, s);
        r.req_track = t[5:0];
        r.req_sector = s[4:0];
        ld_idx = '0;
        return r;
    endfunction

    // Closing a load: nothing written means failure, otherwise the end address.
    function automatic dipcl_pkg::t_result end_of_load();
        dipcl_pkg::t_result r;
        ld_active = 1'b0;
        if (wr_ptr == load_base) return blank_result(dipcl_pkg::KIND_FAIL);
        r = blank_result(dipcl_pkg::KIND_DONE);
        r.end_address = wr_ptr;
        return r;
    endfunction

    // Works out the results one accepted item causes and queues them.
    function automatic void chain_step(dipcl_pkg::t_item it);
        dipcl_pkg::t_result outq[$];
        dipcl_pkg::t_result r;
        logic [7:0]         b;
        logic [7:0]         p;
        logic [7:0]         skip;
        bit                 halt;
        b = it.data_byte;
        halt = 1'b0;
        if (it.cmd == dipcl_pkg::CMD_START) begin
            nx_trk = '0;
            nx_sec = '0;
            used_len = '0;
            wr_ptr = '0;
            load_base = '0;
            secs_done = '0;
            first_sec = 1'b1;
            ld_idx = '0;
            if (link_ok(it.start_track, it.start_sector)) begin
                ld_active = 1'b1;
                outq = {outq, read_request(it.start_track, it.start_sector)};
            end else begin
                ld_active = 1'b0;
                outq = {outq, blank_result(dipcl_pkg::KIND_FAIL)};
            end
        end else if (ld_active) begin
            if (ld_idx == dipcl_pkg::IDX_LINK_TRACK) begin
                nx_trk = b;
            end else if (ld_idx == dipcl_pkg::IDX_LINK_SECTOR) begin
                nx_sec = b;
                used_len = (nx_trk != 8'd0) ? dipcl_pkg::FULL_USED
                                            : ((b >= 8'd2) ? b - 8'd1 : 8'd0);
                // A first sector too short to hold the load address fails at once.
                if (first_sec && used_len < 8'd2) begin
                    ld_active = 1'b0;
                    outq = {outq, blank_result(dipcl_pkg::KIND_FAIL)};
                    halt = 1'b1;
                end
            end else if (first_sec && ld_idx == dipcl_pkg::IDX_LOAD_LO) begin
                load_base = {8'h00, b};
            end else if (first_sec && ld_idx == dipcl_pkg::IDX_LOAD_HI) begin
                load_base[15:8] = b;
                wr_ptr = load_base;
            end else begin
                p = ld_idx - 8'd2;
                skip = first_sec ? 8'd2 : 8'd0;
                if (p >= skip && p < used_len) begin
                    if (wr_ptr >= dipcl_pkg::TOP_ADDR) begin
                        // Pointer already at the top when a sector's payload starts.
                        if (p == skip) begin
                            outq = {outq, end_of_load()};
                            halt = 1'b1;
                        end
                    end else begin
                        r = blank_result(dipcl_pkg::KIND_WRITE);
                        r.ram_address = wr_ptr;
                        r.ram_data = b;
                        outq = {outq, r};
                        wr_ptr++;
                    end
                end
            end
            if (!halt) begin
                if (ld_idx == dipcl_pkg::LAST_BYTE) begin
                    secs_done = secs_done + 10'd1;
                    if (nx_trk == 8'd0 || int'(secs_done) >= disk_sectors()
                            || !link_ok(nx_trk, nx_sec)) begin
                        outq = {outq, end_of_load()};
                    end else begin
                        first_sec = 1'b0;
                        outq = {outq, read_request(nx_trk, nx_sec)};
                    end
                end else begin
                    ld_idx = ld_idx + 8'd1;
                end
            end
        end
        if (outq.size() > 0) outq[outq.size() - 1].last = 1'b1;
        pending_results = {pending_results, outq};
    endfunction

    function automatic void cmp_field(string nm, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, nm, want, got);
            fail_count++;
        end
    endfunction

    // Result checker: every accepted result is matched against the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            case (o_out.kind)
                dipcl_pkg::KIND_WRITE: n_writes++;
                dipcl_pkg::KIND_REQ:   n_reqs++;
                dipcl_pkg::KIND_DONE:  n_done++;
                default:               n_failed++;
            endcase
            if (pending_results.size() == 0) begin
                $display("%0t: result of kind %0d arrived with nothing owed, expected none",
                         $time, o_out.kind);
                fail_count++;
            end else begin
                oldest = pending_results.pop_front();
                cmp_field("kind", oldest.kind, o_out.kind);
                cmp_field("ram_address", oldest.ram_address, o_out.ram_address);
                cmp_field("ram_data", oldest.ram_data, o_out.ram_data);
                cmp_field("image_offset", oldest.image_offset, o_out.image_offset);
                cmp_field("req_track", oldest.req_track, o_out.req_track);
                cmp_field("req_sector", oldest.req_sector, o_out.req_sector);
                cmp_field("end_address", oldest.end_address, o_out.end_address);
                cmp_field("last", oldest.last, o_out.last);
            end
        end
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: run exceeded %0d cycles, %0d results still owed",
                 $time, CYCLE_LIMIT, pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: a random pause before each result, or none in steady stretches.
    // On request it holds off for a long stretch so that the block backs up.
    initial begin
        int pause;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            pause = rx_steady ? 0 : $urandom_range(0, 16);
            if (pause > 0) begin
                i_out_ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Offers one item after a random gap and returns at the edge that accepts it.
    // Valid is left high so that a following item can go out back to back.
    task automatic send_item(input dipcl_pkg::t_item it);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        chain_step(it);
        sent_items++;
    endtask

    task automatic send_start(input logic [7:0] t, input logic [7:0] s);
        dipcl_pkg::t_item it;
        it.cmd = dipcl_pkg::CMD_START;
        it.start_track = t;
        it.start_sector = s;
        it.data_byte = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        dipcl_pkg::t_item it;
        it.cmd = dipcl_pkg::CMD_BYTE;
        it.start_track = 8'($urandom);
        it.start_sector = 8'($urandom);
        it.data_byte = b;
        send_item(it);
    endtask

    // Sends the first nbytes of a sector: link, load address on a first sector,
    // then random payload.
    task automatic send_sector(input logic [7:0] lt, input logic [7:0] ls, input bit first,
                               input logic [15:0] la, input int nbytes);
        logic [7:0] b;
        int i;
        for (i = 0; i < nbytes; i++) begin
            if (i == dipcl_pkg::IDX_LINK_TRACK) b = lt;
            else if (i == dipcl_pkg::IDX_LINK_SECTOR) b = ls;
            else if (first && i == dipcl_pkg::IDX_LOAD_LO) b = la[7:0];
            else if (first && i == dipcl_pkg::IDX_LOAD_HI) b = la[15:8];
            else b = 8'($urandom);
            send_byte(b);
        end
    endtask

    // Stops offering items and lets the block drain completely.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_track_count(input logic [5:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tracks_cfg = v;
    endtask

    task automatic pick_sector(output logic [7:0] t, output logic [7:0] s);
        t = 8'($urandom_range(1, tracks_cfg));
        s = 8'($urandom_range(0, zone_sectors(t) - 1));
    endtask

    // A link the loader must refuse: track beyond the image, or sector beyond its zone.
    task automatic pick_bad_link(output logic [7:0] t, output logic [7:0] s);
        if ($urandom_range(0, 1)) begin
            t = 8'($urandom_range(tracks_cfg + 1, 255));
            s = 8'($urandom);
        end else begin
            pick_sector(t, s);
            s = 8'($urandom_range(zone_sectors(t), 255));
        end
    endtask

    // One file: a valid start, then the opening bytes of its first sector. The link
    // ends the chain with a used length, names a sector the loader must refuse, or
    // names a good one; unless it fails, the load is left open for the next start to interrupt.
    task automatic run_chain(input bit near_top);
        logic [7:0]  t;
        logic [7:0]  s;
        logic [15:0] la;
        int          cut;
        pick_sector(t, s);
        send_start(t, s);
        la = near_top ? 16'hFFF0 + 16'($urandom_range(0, 15)) : 16'($urandom);
        case ($urandom_range(0, 3))
            0, 1: begin
                t = 8'd0;
                s = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            end
            2: pick_bad_link(t, s);
            default: pick_sector(t, s);
        endcase
        cut = $urandom_range(2, CHAIN_BYTES);
        send_sector(t, s, 1'b1, la, cut);
    endtask

    // Start checks at the reset track count: zone borders, track 0, the last
    // track and the one past it, and the field extremes.
    task automatic test_start_checks();
        logic [7:0] trk [12];
        logic [7:0] sec [12];
        int i;
        trk = '{8'd0, 8'd1, 8'd17, 8'd17, 8'd18, 8'd24, 8'd25, 8'd30, 8'd31, 8'd35, 8'd36,
                8'd255};
        sec = '{8'd0, 8'd0, 8'd20, 8'd21, 8'd18, 8'd19, 8'd17, 8'd18, 8'd16, 8'd17, 8'd0,
                8'd255};
        for (i = 0; i < 12; i++) send_start(trk[i], sec[i]);
        // The last start failed, so these bytes find the loader idle.
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_idle();
    endtask

    // Restart mid-sector, a first sector too short for a load address, and a
    // load address at the very top of RAM.
    task automatic test_short_loads();
        send_start(8'd1, 8'd0);
        send_sector(8'd2, 8'd3, 1'b1, 16'h0801, 3);
        send_start(8'd2, 8'd5);
        send_sector(8'd0, 8'd1, 1'b1, 16'h0000, 2);
        send_start(8'd3, 8'd3);
        send_sector(8'd0, 8'd2, 1'b1, 16'h0000, 2);
        send_start(8'd4, 8'd0);
        send_sector(8'd0, 8'hFF, 1'b1, 16'hFFFF, 5);
        wait_idle();
    endtask

    task automatic test_track_count();
        set_track_count(6'd42);
        send_start(8'd42, 8'd16);
        send_start(8'd42, 8'd17);
        send_start(8'd43, 8'd0);
        send_start(8'd36, 8'd5);
        wait_idle();
    endtask

    // Pointer running into the top of RAM: within a sector, across a sector
    // boundary, and with only one byte of room left.
    task automatic test_ram_top();
        send_start(8'd1, 8'd0);
        send_sector(8'd18, 8'd0, 1'b1, 16'hFFF0, dipcl_pkg::SECTOR_BYTES);
        send_sector(8'd1, 8'd1, 1'b0, 16'h0000, 3);
        send_start(8'd2, 8'd0);
        send_sector(8'd0, 8'hFF, 1'b1, 16'hFFFE, ROOM_BYTES);
        wait_idle();
    endtask

    // The receiver holds off while a full sector streams in with no gaps.
    task automatic test_output_stall();
        tx_steady = 1'b1;
        hold_req = 1'b1;
        send_start(8'd5, 8'd3);
        send_sector(8'd0, 8'd200, 1'b1, 16'h2000, dipcl_pkg::SECTOR_BYTES);
        wait_idle();
        tx_steady = 1'b0;
    endtask

    // Random files under several track counts, mixed with stray bytes and
    // starts that are likely to be refused.
    task automatic test_random_chains();
        logic [5:0] counts [4];
        int ph;
        int first_item;
        mid_tracks = $urandom_range(36, 41);
        counts = '{6'd42, 6'(mid_tracks), 6'd35, 6'd42};
        for (ph = 0; ph < 4; ph++) begin
            if (counts[ph] != tracks_cfg) set_track_count(counts[ph]);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            first_item = sent_items;
            while (sent_items - first_item < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0: send_start(8'($urandom), 8'($urandom));
                    1: send_byte(8'($urandom));
                    default: run_chain($urandom_range(0, 9) == 0);
                endcase
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_start_checks();
        test_short_loads();
        test_track_count();
        test_ram_top();
        test_output_stall();
        test_random_chains();
        $display("Loader run: %0d items, track counts 35, 42 and %0d, with a long output stall.",
                 sent_items, mid_tracks);
        $display("Checked %0d ram writes, %0d sector requests, %0d loads done, %0d failed.",
                 n_writes, n_reqs, n_done, n_failed);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
